// ===== hdl/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  // Opcode that ends the stream
  localparam logic [3:0] OP_CLOSE = 4'h8;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Kind of word passed from parser to output side
  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_DATA,
    KIND_MARK
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e kind;
    logic [7:0]  data;
    logic [1:0]  key_idx;
    logic        masked;
    logic        last;
    logic [3:0]  opcode;
    logic        fin;
  } wsd_entry_t;

endpackage

// ===== hdl/wsd_front.sv =====
// Header parser: decodes frame headers, counts payload, classifies each byte.
module wsd_front import wsd_pkg::*; #(
  parameter int LengthWidth = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output wsd_entry_t entry_o
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [LengthWidth-1:0] LenMax = '1;

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [3:0]             op_q, op_d;
  logic                   fin_q, fin_d;
  logic                   masked_q, masked_d;
  logic [LengthWidth-1:0] rem_q, rem_d;
  logic [1:0]             idx_q, idx_d;
  logic                   closed_q, closed_d;

  logic                   len_done, sel_masked, start_pay, frame_end;
  logic [LengthWidth-1:0] sel_rem, ext_rem;
  logic [6:0]             len7;

  assign len7 = rx_byte_i[6:0];

  // Shift in one extension byte, saturating when it would overflow
  always_comb begin
    if (rem_q[LengthWidth-1 -: 8] != 8'd0) begin
      ext_rem = LenMax;
    end else begin
      ext_rem = {rem_q[LengthWidth-9:0], rx_byte_i};
    end
  end

  // Parse state update
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    fin_d      = fin_q;
    masked_d   = masked_q;
    rem_d      = rem_q;
    idx_d      = idx_q;
    closed_d   = closed_q;
    len_done   = 1'b0;
    sel_masked = masked_q;
    sel_rem    = rem_q;
    start_pay  = 1'b0;
    frame_end  = 1'b0;
    push_o     = 1'b0;
    entry_o.kind    = KIND_DATA;
    entry_o.data    = rx_byte_i;
    entry_o.key_idx = idx_q;
    entry_o.masked  = masked_q;
    entry_o.last    = 1'b0;
    entry_o.opcode  = op_q;
    entry_o.fin     = fin_q;

    if (accept_i && !closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = rx_byte_i[7];
          rem_d    = '0;
          if (len7 == LEN_EXT16) begin
            cnt_d   = EXT16_BYTES;
            phase_d = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            cnt_d   = EXT64_BYTES;
            phase_d = PH_EXT;
          end else begin
            rem_d      = LengthWidth'(len7);
            len_done   = 1'b1;
            sel_masked = rx_byte_i[7];
            sel_rem    = LengthWidth'(len7);
          end
        end
        PH_EXT: begin
          rem_d = ext_rem;
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            len_done = 1'b1;
            sel_rem  = ext_rem;
          end
        end
        PH_KEY: begin
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            start_pay = 1'b1;
          end else begin
            push_o       = 1'b1;
            entry_o.kind = KIND_KEY;
          end
          // last key byte still loads the key unless the frame is empty
          if (cnt_q == 4'd1 && rem_q != '0) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_KEY;
          end
        end
        PH_DATA: begin
          push_o       = 1'b1;
          entry_o.kind = KIND_DATA;
          entry_o.last = (rem_q == LengthWidth'(1));
          idx_d        = idx_q + 2'd1;
          rem_d        = rem_q - LengthWidth'(1);
          frame_end    = (rem_q == LengthWidth'(1));
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Length known: key next, or straight to payload
      if (len_done) begin
        if (sel_masked) begin
          phase_d = PH_KEY;
          cnt_d   = KEY_BYTES;
        end else begin
          start_pay = 1'b1;
        end
      end

      // Payload start; an empty frame gives one marker word
      if (start_pay) begin
        idx_d = 2'd0;
        if (sel_rem == '0) begin
          push_o         = 1'b1;
          entry_o.kind   = KIND_MARK;
          entry_o.data   = 8'd0;
          entry_o.masked = 1'b0;
          entry_o.last   = 1'b1;
          frame_end      = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end

      if (frame_end) begin
        phase_d = PH_HDR0;
        if (op_q == OP_CLOSE) begin
          closed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= '0;
      op_q     <= '0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      idx_q    <= '0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      idx_q    <= idx_d;
      closed_q <= closed_d;
    end
  end

  // Once closed, the parser stays closed
  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q) else $error("closed flag dropped");

  // Payload phase always has bytes left
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0)) else $error("payload phase with zero length");

  // Nothing is pushed once closed
  a_no_push_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> !push_o) else $error("word pushed after close");

endmodule

// ===== hdl/wsd_queue.sv =====
// Two-entry queue between parser and output side.
module wsd_queue import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wsd_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  output wsd_entry_t entry_o,
  input  logic       pop_i
);

  wsd_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

endmodule

// ===== hdl/wsd_back.sv =====
// Output side: holds the masking key, unmasks payload, drives the result register.
module wsd_back import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  wsd_entry_t q_entry_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       is_payload_o,
  output logic       last_of_frame_o,
  output logic [3:0] frame_opcode_o,
  output logic       frame_fin_o,
  output logic       close_seen_o
);

  logic [31:0] key_q;
  logic        valid_q;
  logic [7:0]  data_q;
  logic        isp_q, last_q, fin_q, close_q;
  logic [3:0]  op_q;

  logic        is_key, load_out;
  logic [7:0]  key_byte;

  assign is_key   = (q_entry_i.kind == KIND_KEY);
  assign load_out = q_valid_i && !is_key && (!valid_q || out_ready_i);
  assign q_pop_o  = q_valid_i && (is_key || !valid_q || out_ready_i);

  // Key octet for this payload byte; first key byte sits in the top octet
  always_comb begin
    case (q_entry_i.key_idx)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Key shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (q_valid_i && is_key) begin
      key_q <= {key_q[23:0], q_entry_i.data};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_out) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      data_q  <= q_entry_i.masked ? (q_entry_i.data ^ key_byte) : q_entry_i.data;
      isp_q   <= (q_entry_i.kind == KIND_DATA);
      last_q  <= q_entry_i.last;
      op_q    <= q_entry_i.opcode;
      fin_q   <= q_entry_i.fin;
      close_q <= (q_entry_i.opcode == OP_CLOSE);
    end
  end

  assign out_valid_o     = valid_q;
  assign data_byte_o     = data_q;
  assign is_payload_o    = isp_q;
  assign last_of_frame_o = last_q;
  assign frame_opcode_o  = op_q;
  assign frame_fin_o     = fin_q;
  assign close_seen_o    = close_q;

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !load_out) else $error("result overwritten");

  // Key words are always taken at once
  a_key_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && is_key) |-> q_pop_o) else $error("key word stalled");

  // A stalled result stays valid with its byte held
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled result changed");

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
//
// Input channel: one stream byte per word on rx_byte_i, in_valid_i / in_ready_o.
// Output channel: one result word per payload byte, or one marker word
// (is_payload_o low) for a frame of zero length; out_valid_o / out_ready_i.
// Header bytes give no output word; the final word of a frame has
// last_of_frame_o set. After a close frame ends, further bytes are taken and
// dropped until reset.
// Throughput: one byte per cycle while out_ready_i stays high. The header
// parser updates its length counter and phase for each accepted byte.
// Path: the parser pushes each word into a 2-entry queue, from which the
// output register takes it.
// Reset clears the parser to expect a new frame, empties the queue and
// drops any pending result. When the receiver stalls, the output register
// holds its word, the queue fills, and in_ready_o falls once it is full.
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       is_payload_o,
  output logic       last_of_frame_o,
  output logic [3:0] frame_opcode_o,
  output logic       frame_fin_o,
  output logic       close_seen_o
);

  logic       accept, push, full, q_valid, q_pop;
  wsd_entry_t push_entry, q_entry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  wsd_front #(
    .LengthWidth(LENGTH_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_o     (data_byte_o),
    .is_payload_o    (is_payload_o),
    .last_of_frame_o (last_of_frame_o),
    .frame_opcode_o  (frame_opcode_o),
    .frame_fin_o     (frame_fin_o),
    .close_seen_o    (close_seen_o)
  );

endmodule
